/* design/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants for the ray/sphere intersection block
// Queue item layout, vector type and queue depth default.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int RSI_QDEPTH = 16;

  // three 32-bit Q16.16 components, index 0 = x
  typedef logic [2:0][31:0] vec3_t;

  // item handed from the front part to the back part
  typedef struct packed {
    logic         ok;    // discriminant non-negative and direction non-zero
    logic [127:0] disc;  // a*R^2 - |S x D|^2
    logic [66:0]  h;     // S.D, signed
    logic [63:0]  a;     // D.D
    vec3_t        o;
    vec3_t        d;
    vec3_t        c;
  } q_t;

endpackage

/* design/rsi_mul64.sv */
// ----------------------------------------------------------------------------
// rsi_mul64: two-stage 64x64 unsigned multiplier
// Four 32x32 partial products registered, then summed into a registered result.
// ----------------------------------------------------------------------------
module rsi_mul64 (
  input  logic         clk,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);

  logic [63:0] ll, lh, hl, hh;

  always_ff @(posedge clk) begin
    ll <= a[31:0] * b[31:0];
    lh <= a[31:0] * b[63:32];
    hl <= a[63:32] * b[31:0];
    hh <= a[63:32] * b[63:32];
    p  <= {64'd0, ll} + {32'd0, lh, 32'd0} + {32'd0, hl, 32'd0} + {hh, 64'd0};
  end

endmodule

/* design/rsi_fifo.sv */
// ----------------------------------------------------------------------------
// rsi_fifo: small register queue between front and back
// Writes at the tail, head readable while not empty.
// ----------------------------------------------------------------------------
module rsi_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  assign dout  = mem[rp];
  assign empty = (cnt == '0);

endmodule

/* design/rsi_front.sv */
// ----------------------------------------------------------------------------
// rsi_front: accept stage and quadratic setup
// Forms S = O - C, a = D.D, h = S.D and the discriminant, flags misses.
// ----------------------------------------------------------------------------
module rsi_front import rsi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_fire,
  input  vec3_t       o_in,
  input  vec3_t       d_in,
  input  vec3_t       c_in,
  input  logic [30:0] r_in,
  output logic        push,
  output q_t          push_data
);

  typedef struct packed {
    logic [66:0] h;
    logic [63:0] a;
    vec3_t       o;
    vec3_t       d;
    vec3_t       c;
  } fs_t;

  logic [6:0] fv;

  vec3_t            o0, d0, c0;
  logic [30:0]      r0;
  logic [2:0][32:0] s0;

  logic signed [64:0] sdp [3];
  logic signed [64:0] pap [3];
  logic signed [64:0] pbp [3];
  logic signed [63:0] ddp [3];
  logic [61:0]        rrp;

  logic [2:0][64:0] sd1, pa1, pb1;
  logic [2:0][62:0] dd1;
  logic [61:0]      rr1;
  vec3_t            o1, d1, c1;

  logic [65:0]      crd [3];
  logic [65:0]      crn [3];
  logic [63:0]      a2;
  logic [66:0]      h2;
  logic [2:0][63:0] cm2;
  logic [61:0]      rr2;
  vec3_t            o2, d2, c2;

  fs_t              fs3, fs4, fs5;
  logic [127:0]     sq4 [3];
  logic [127:0]     ar4;
  logic [129:0]     x5;
  logic [127:0]     ar5;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else begin
      fv <= {fv[5:0], in_fire};
    end
  end

  // products of the setup stage
  for (genvar i = 0; i < 3; i++) begin : g_prod
    localparam int J = (i + 1) % 3;
    localparam int L = (i + 2) % 3;
    assign sdp[i] = $signed(s0[i]) * $signed(d0[i]);
    assign pap[i] = $signed(s0[J]) * $signed(d0[L]);
    assign pbp[i] = $signed(s0[L]) * $signed(d0[J]);
    assign ddp[i] = $signed(d0[i]) * $signed(d0[i]);
    assign crd[i] = {pa1[i][64], pa1[i]} - {pb1[i][64], pb1[i]};
    assign crn[i] = -crd[i];
  end
  assign rrp = r0 * r0;

  always_ff @(posedge clk) begin
    // F0: capture, form S
    o0 <= o_in;
    d0 <= d_in;
    c0 <= c_in;
    r0 <= r_in;
    for (int i = 0; i < 3; i++) begin
      s0[i] <= {o_in[i][31], o_in[i]} - {c_in[i][31], c_in[i]};
    end
    // F1: products
    for (int i = 0; i < 3; i++) begin
      sd1[i] <= sdp[i];
      pa1[i] <= pap[i];
      pb1[i] <= pbp[i];
      dd1[i] <= ddp[i][62:0];
    end
    rr1 <= rrp;
    o1  <= o0;
    d1  <= d0;
    c1  <= c0;
    // F2: sums, cross product magnitudes (each below 2^64)
    a2 <= {1'b0, dd1[0]} + {1'b0, dd1[1]} + {1'b0, dd1[2]};
    h2 <= {{2{sd1[0][64]}}, sd1[0]} + {{2{sd1[1][64]}}, sd1[1]}
        + {{2{sd1[2][64]}}, sd1[2]};
    for (int i = 0; i < 3; i++) begin
      cm2[i] <= crd[i][65] ? crn[i][63:0] : crd[i][63:0];
    end
    rr2 <= rr1;
    o2  <= o1;
    d2  <= d1;
    c2  <= c1;
    // side data alongside the multipliers
    fs3 <= '{h: h2, a: a2, o: o2, d: d2, c: c2};
    fs4 <= fs3;
    // F4: |S x D|^2 with headroom for overflow
    x5  <= {2'b00, sq4[0]} + {2'b00, sq4[1]} + {2'b00, sq4[2]};
    ar5 <= ar4;
    fs5 <= fs4;
    // F5: classify
    push_data.ok   <= (fs5.a != '0) && (x5[129:128] == 2'b00) && (ar5 >= x5[127:0]);
    push_data.disc <= ar5 - x5[127:0];
    push_data.h    <= fs5.h;
    push_data.a    <= fs5.a;
    push_data.o    <= fs5.o;
    push_data.d    <= fs5.d;
    push_data.c    <= fs5.c;
  end

  for (genvar i = 0; i < 3; i++) begin : g_sq
    rsi_mul64 u_sq (.clk(clk), .a(cm2[i]), .b(cm2[i]), .p(sq4[i]));
  end
  rsi_mul64 u_ar (.clk(clk), .a(a2), .b({2'b00, rr2}), .p(ar4));

  assign push = fv[6];

endmodule

/* design/rsi_back.sv */
// ----------------------------------------------------------------------------
// rsi_back: root, distance, hit point and normal pipeline
// Square root, root select, long division, hit point, normalization.
// ----------------------------------------------------------------------------
module rsi_back import rsi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  q_t                 qd,
  input  logic               q_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [30:0]        hit_distance,
  output logic signed [31:0] hit_point_x,
  output logic signed [31:0] hit_point_y,
  output logic signed [31:0] hit_point_z,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic signed [17:0] normal_z
);

  localparam int NSQ = 64;
  localparam int NDV = 31;
  localparam int NNM = 17;
  localparam int NST = NSQ + 2 + NDV + 5 + NNM + 1;
  localparam logic [30:0] T_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic         ok;
    logic [66:0]  h;
    logic [63:0]  a;
    vec3_t        o;
    vec3_t        d;
    vec3_t        c;
    logic [65:0]  rem;
    logic [63:0]  root;
    logic [127:0] rad;
  } sq_t;

  typedef struct packed {
    logic        ok;
    logic        sat;
    logic [63:0] a;
    logic [95:0] num;
    logic [30:0] t;
    vec3_t       o;
    vec3_t       d;
    vec3_t       c;
  } dv_t;

  typedef struct packed {
    logic [97:0]  x2;
    logic [105:0] sn2;
    logic [85:0]  sn;
    logic [16:0]  n;
    logic         neg;
  } ln_t;

  typedef struct packed {
    logic            ok;
    logic [30:0]     t;
    vec3_t           p;
    logic [67:0]     vs;
    logic [2:0][$bits(ln_t)-1:0] ln;
  } nm_t;

  // one digit of the square root per stage
  function automatic sq_t sq_step(sq_t x);
    logic [67:0] rem2, trial, diff;
    sq_t y;
    y     = x;
    rem2  = {x.rem, x.rad[127:126]};
    trial = {2'b00, x.root, 2'b01};
    diff  = rem2 - trial;
    if (rem2 >= trial) begin
      y.rem  = diff[65:0];
      y.root = {x.root[62:0], 1'b1};
    end else begin
      y.rem  = rem2[65:0];
      y.root = {x.root[62:0], 1'b0};
    end
    y.rad = {x.rad[125:0], 2'b00};
    return y;
  endfunction

  // one quotient bit per stage
  function automatic dv_t dv_step(dv_t x, int k);
    logic [95:0] dvs;
    dv_t y;
    y   = x;
    dvs = {32'd0, x.a} << k;
    if (!x.sat && x.num >= dvs) begin
      y.num  = x.num - dvs;
      y.t[k] = 1'b1;
    end
    return y;
  endfunction

  // one bit of floor(|v| * 2^16 / |V|) per lane, tracking s*n and s*n^2
  function automatic nm_t nm_step(nm_t x, int b);
    logic [105:0] cand;
    ln_t l;
    nm_t y;
    y = x;
    for (int i = 0; i < 3; i++) begin
      l    = ln_t'(x.ln[i]);
      cand = l.sn2 + ({20'd0, l.sn} << (b + 1)) + ({38'd0, x.vs} << (2 * b));
      if (!l.n[16] && {8'd0, l.x2} >= cand) begin
        l.sn2  = cand;
        l.sn   = l.sn + ({18'd0, x.vs} << b);
        l.n[b] = 1'b1;
      end
      y.ln[i] = l;
    end
    return y;
  endfunction

  function automatic logic [31:0] sat32(logic signed [63:0] v);
    if (v[63:31] == '0 || v[63:31] == '1) begin
      return v[31:0];
    end else if (v[63]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

  logic           en;
  logic [NST-1:0] bv;

  sq_t sq [NSQ];
  sq_t sq_in;

  logic               rg_ok;
  logic [67:0]        rg_n;
  logic [63:0]        rg_a;
  vec3_t              rg_o, rg_d, rg_c;
  logic signed [67:0] qs, hs, nh;
  logic               miss, near;

  dv_t dv [NDV + 1];
  dv_t dv_in;

  logic [30:0]        tf;
  logic signed [63:0] prod [3];
  logic               h1_ok;
  logic [30:0]        h1_t;
  logic [2:0][63:0]   h1_prod;
  vec3_t              h1_o, h1_c;

  logic               h2_ok;
  logic [30:0]        h2_t;
  vec3_t              h2_p, h2_c;

  logic               h3_ok;
  logic [30:0]        h3_t;
  vec3_t              h3_p;
  logic [2:0][32:0]   h3_mag;
  logic [2:0]         h3_neg;
  logic [32:0]        vd [3];
  logic [32:0]        vn [3];

  logic               h4_ok;
  logic [30:0]        h4_t;
  vec3_t              h4_p;
  logic [2:0][65:0]   h4_sq;
  logic [2:0]         h4_neg;

  nm_t nm [NNM + 1];
  nm_t nm_in;
  ln_t ln_fin [3];
  logic signed [17:0] nrm [3];

  assign en        = !bv[NST-1] || out_ready;
  assign pop       = en && !q_empty;
  assign out_valid = bv[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
    end else if (en) begin
      bv <= {bv[NST-2:0], pop};
    end
  end

  // square root of the discriminant
  always_comb begin
    sq_in      = '0;
    sq_in.ok   = qd.ok;
    sq_in.h    = qd.h;
    sq_in.a    = qd.a;
    sq_in.o    = qd.o;
    sq_in.d    = qd.d;
    sq_in.c    = qd.c;
    sq_in.rad  = qd.disc;
  end

  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (en) begin
        sq[g] <= sq_step((g == 0) ? sq_in : sq[(g == 0) ? 0 : g - 1]);
      end
    end
  end

  // root selection: near root if -h > q, far root if q >= h, else miss
  assign qs   = {4'd0, sq[NSQ-1].root};
  assign hs   = {sq[NSQ-1].h[66], sq[NSQ-1].h};
  assign nh   = -hs;
  assign miss = qs < hs;
  assign near = qs < nh;

  always_ff @(posedge clk) begin
    if (en) begin
      rg_ok <= sq[NSQ-1].ok && !miss;
      rg_n  <= near ? nh - qs : qs - hs;
      rg_a  <= sq[NSQ-1].a;
      rg_o  <= sq[NSQ-1].o;
      rg_d  <= sq[NSQ-1].d;
      rg_c  <= sq[NSQ-1].c;
    end
  end

  // division t = n * 2^16 / a, saturated
  always_comb begin
    dv_in     = '0;
    dv_in.ok  = rg_ok;
    dv_in.a   = rg_a;
    dv_in.num = {12'd0, rg_n, 16'd0};
    dv_in.sat = {12'd0, rg_n, 16'd0} >= {1'b0, rg_a, 31'd0};
    dv_in.o   = rg_o;
    dv_in.d   = rg_d;
    dv_in.c   = rg_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= dv_in;
    end
  end

  for (genvar j = 0; j < NDV; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1] <= dv_step(dv[j], NDV - 1 - j);
      end
    end
  end

  // hit point P = O + floor(t*D / 2^16)
  assign tf = dv[NDV].sat ? T_MAX : dv[NDV].t;
  for (genvar i = 0; i < 3; i++) begin : g_hp
    assign prod[i] = $signed({1'b0, tf}) * $signed(dv[NDV].d[i]);
    assign vd[i]   = {h2_p[i][31], h2_p[i]} - {h2_c[i][31], h2_c[i]};
    assign vn[i]   = -vd[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_ok <= dv[NDV].ok;
      h1_t  <= tf;
      h1_o  <= dv[NDV].o;
      h1_c  <= dv[NDV].c;
      for (int i = 0; i < 3; i++) begin
        h1_prod[i] <= prod[i];
      end
      h2_ok <= h1_ok;
      h2_t  <= h1_t;
      h2_c  <= h1_c;
      for (int i = 0; i < 3; i++) begin
        h2_p[i] <= sat32($signed({{32{h1_o[i][31]}}, h1_o[i]})
                         + ($signed(h1_prod[i]) >>> 16));
      end
      h3_ok <= h2_ok;
      h3_t  <= h2_t;
      h3_p  <= h2_p;
      for (int i = 0; i < 3; i++) begin
        h3_neg[i] <= vd[i][32];
        h3_mag[i] <= vd[i][32] ? vn[i] : vd[i];
      end
      h4_ok  <= h3_ok;
      h4_t   <= h3_t;
      h4_p   <= h3_p;
      h4_neg <= h3_neg;
      for (int i = 0; i < 3; i++) begin
        h4_sq[i] <= h3_mag[i] * h3_mag[i];
      end
    end
  end

  // normalization setup: |V|^2 and the scaled squares
  always_comb begin
    ln_t l;
    nm_in    = '0;
    nm_in.ok = h4_ok;
    nm_in.t  = h4_t;
    nm_in.p  = h4_p;
    nm_in.vs = {2'b00, h4_sq[0]} + {2'b00, h4_sq[1]} + {2'b00, h4_sq[2]};
    for (int i = 0; i < 3; i++) begin
      l          = '0;
      l.x2       = {h4_sq[i], 32'd0};
      l.neg      = h4_neg[i];
      nm_in.ln[i] = l;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm[0] <= nm_in;
    end
  end

  for (genvar j = 0; j < NNM; j++) begin : g_nrm
    always_ff @(posedge clk) begin
      if (en) begin
        nm[j+1] <= nm_step(nm[j], NNM - 1 - j);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_fin
    assign ln_fin[i] = ln_t'(nm[NNM].ln[i]);
    assign nrm[i]    = (!nm[NNM].ok || nm[NNM].vs == '0) ? 18'sd0 :
                       ln_fin[i].neg ? -$signed({1'b0, ln_fin[i].n}) :
                       $signed({1'b0, ln_fin[i].n});
  end

  // output register; a miss reports all zero
  always_ff @(posedge clk) begin
    if (en) begin
      hit          <= nm[NNM].ok;
      hit_distance <= nm[NNM].ok ? nm[NNM].t : '0;
      hit_point_x  <= nm[NNM].ok ? nm[NNM].p[0] : '0;
      hit_point_y  <= nm[NNM].ok ? nm[NNM].p[1] : '0;
      hit_point_z  <= nm[NNM].ok ? nm[NNM].p[2] : '0;
      normal_x     <= nrm[0];
      normal_y     <= nrm[1];
      normal_z     <= nrm[2];
    end
  end

endmodule

/* design/ray_sphere_intersect.sv */
// ----------------------------------------------------------------------------
// ray_sphere_intersect: one ray against one sphere per item
// Q16.16 fixed-point quadratic solve with hit point and unit normal.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one ray plus one sphere per
//   item; output channel (out_valid/out_ready) carries one result per item,
//   in order. A miss (zero direction, negative discriminant, sphere behind
//   the ray) gives hit = 0 with every other field zero.
//   Throughput: one item per cycle while out_ready stays high.
//   From accept to out_valid an item passes the front setup, the queue and
//   the 120 back stages. The back is dominated by the 64-stage square root
//   of the 128-bit discriminant, the 31-stage distance divider and the
//   17-stage normalization.
//   in_ready is driven from an occupancy count covering the front stages and
//   the queue, so the front never stalls; it drops once the count reaches QDEPTH.
//   When the receiver stalls, the whole back pipeline holds, the result
//   stays on the ports, and the front keeps filling the queue.
//   Reset (rst, synchronous) empties the pipeline and the queue; no item is
//   in flight afterwards.
// ----------------------------------------------------------------------------
module ray_sphere_intersect import rsi_pkg::*; #(
  parameter int QDEPTH = RSI_QDEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] ray_origin_x,
  input  logic signed [31:0] ray_origin_y,
  input  logic signed [31:0] ray_origin_z,
  input  logic signed [31:0] ray_dir_x,
  input  logic signed [31:0] ray_dir_y,
  input  logic signed [31:0] ray_dir_z,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        radius,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [30:0]        hit_distance,
  output logic signed [31:0] hit_point_x,
  output logic signed [31:0] hit_point_y,
  output logic signed [31:0] hit_point_z,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic signed [17:0] normal_z
);

  localparam int CW = $clog2(QDEPTH + 1);
  localparam int QW = $bits(q_t);

  logic          in_fire;
  logic [CW-1:0] occ;      // items in the front stages plus the queue
  logic          push, pop, q_empty;
  q_t            push_data, qd;
  logic [QW-1:0] q_dout;
  vec3_t         o_in, d_in, c_in;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (occ < CW'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + CW'(in_fire) - CW'(pop);
    end
  end

  assign o_in = {ray_origin_z, ray_origin_y, ray_origin_x};
  assign d_in = {ray_dir_z, ray_dir_y, ray_dir_x};
  assign c_in = {center_z, center_y, center_x};

  rsi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .o_in      (o_in),
    .d_in      (d_in),
    .c_in      (c_in),
    .r_in      (radius),
    .push      (push),
    .push_data (push_data)
  );

  // occupancy count guarantees the queue never overflows
  rsi_fifo #(.W(QW), .DEPTH(QDEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_data),
    .pop   (pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign qd = q_t'(q_dout);

  rsi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qd           (qd),
    .q_empty      (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .hit_distance (hit_distance),
    .hit_point_x  (hit_point_x),
    .hit_point_y  (hit_point_y),
    .hit_point_z  (hit_point_z),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z)
  );

endmodule

/* design/rsi_checker.sv */
// ----------------------------------------------------------------------------
// rsi_checker: port-level checks for ray_sphere_intersect
// Reset behavior, stall hold and miss encoding.
// ----------------------------------------------------------------------------
module rsi_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               hit,
  input logic [30:0]        hit_distance,
  input logic signed [31:0] hit_point_x,
  input logic signed [31:0] hit_point_y,
  input logic signed [31:0] hit_point_z,
  input logic signed [17:0] normal_x,
  input logic signed [17:0] normal_y,
  input logic signed [17:0] normal_z
);

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  // stalled result holds: out_valid, hit, hit_distance, hit_point_x and normal_x stay
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_distance)
      && $stable(hit_point_x) && $stable(normal_x))
    else $error("result changed under stall");

  // a miss carries an all-zero result
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_distance == 0 && hit_point_x == 0 && hit_point_y == 0
      && hit_point_z == 0 && normal_x == 0 && normal_y == 0 && normal_z == 0)
    else $error("miss with non-zero fields");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ray_sphere_intersect
// Feeds rays and spheres over valid/ready, predicts each hit record with an
// exact wide-integer solver and checks results in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import rsi_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    vec3_t       o;
    vec3_t       d;
    vec3_t       c;
    logic [30:0] r;
  } ray_item_t;

  typedef struct packed {
    logic             hit;
    logic [30:0]      distance;
    vec3_t            p;
    logic [2:0][17:0] n;
  } hit_rec_t;

  localparam wide_t COORD_MAX = 2147483647;
  localparam wide_t COORD_MIN = -COORD_MAX - 1;
  localparam wide_t DIST_MAX  = 2147483647;
  localparam wide_t UNIT      = 65536;
  localparam int    STALL_LIMIT = 20000;
  localparam int    DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] ray_origin_x, ray_origin_y, ray_origin_z;
  logic signed [31:0] ray_dir_x, ray_dir_y, ray_dir_z;
  logic signed [31:0] center_x, center_y, center_z;
  logic [30:0] radius;
  logic hit;
  logic [30:0] hit_distance;
  logic signed [31:0] hit_point_x, hit_point_y, hit_point_z;
  logic signed [17:0] normal_x, normal_y, normal_z;

  ray_item_t ray_q[$];     // rays waiting to be driven
  hit_rec_t  hit_exp_q[$]; // predicted hit records, oldest first
  ray_item_t cur_ray;
  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  ray_sphere_intersect dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .ray_origin_x(ray_origin_x), .ray_origin_y(ray_origin_y),
    .ray_origin_z(ray_origin_z),
    .ray_dir_x(ray_dir_x), .ray_dir_y(ray_dir_y), .ray_dir_z(ray_dir_z),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .radius(radius),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .hit_distance(hit_distance),
    .hit_point_x(hit_point_x), .hit_point_y(hit_point_y),
    .hit_point_z(hit_point_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
  );

  // Exact solver: a*t^2 + 2h*t + c = 0, disc/4 = a*R^2 - |S x D|^2.
  function automatic hit_rec_t solve_hit(ray_item_t it);
    hit_rec_t res;
    wide_t o[3], d[3], c[3], s[3], p[3], v[3];
    wide_t a, h, x2, cr, ar2, rr, disc, q, trial, n, num, t, vs, mg, cc, nn;
    int j, l;
    res = '0;
    a = 0;
    h = 0;
    x2 = 0;
    vs = 0;
    for (int i = 0; i < 3; i++) begin
      o[i] = $signed(it.o[i]);
      d[i] = $signed(it.d[i]);
      c[i] = $signed(it.c[i]);
      s[i] = o[i] - c[i];
      a += d[i] * d[i];
      h += s[i] * d[i];
    end
    if (a == 0) return res;                // zero direction
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      l = (i + 2) % 3;
      cr = s[j] * d[l] - s[l] * d[j];
      x2 += cr * cr;
    end
    if (x2[255:128] != 0) return res;      // cross term beyond 128 bits
    rr = it.r;
    ar2 = a * rr * rr;
    if (ar2 < x2) return res;              // negative discriminant
    disc = ar2 - x2;
    q = 0;
    for (int b = 63; b >= 0; b--) begin
      trial = q;
      trial[b] = 1'b1;
      if (trial * trial <= disc) q = trial;
    end
    if (q < h) return res;                 // sphere behind the ray
    n = (q < -h) ? -h - q : q - h;         // near root if positive
    num = n <<< 16;
    t = (num >= (a <<< 31)) ? DIST_MAX : num / a;
    for (int i = 0; i < 3; i++) begin
      p[i] = o[i] + ((t * d[i]) >>> 16);
      if (p[i] > COORD_MAX) p[i] = COORD_MAX;
      if (p[i] < COORD_MIN) p[i] = COORD_MIN;
      v[i] = p[i] - c[i];
      vs += v[i] * v[i];
    end
    for (int i = 0; i < 3; i++) begin
      nn = 0;
      if (vs != 0) begin
        mg = ((v[i] < 0) ? -v[i] : v[i]) <<< 16;
        for (int b = 16; b >= 0; b--) begin
          cc = nn;
          cc[b] = 1'b1;
          if (cc <= UNIT && mg * mg >= vs * cc * cc) nn = cc;
        end
      end
      res.n[i] = 18'((v[i] < 0) ? -nn : nn);
      res.p[i] = 32'(p[i]);
    end
    res.hit = 1'b1;
    res.distance = 31'(t);
    return res;
  endfunction

  // Random coordinate with random magnitude so small and huge values both occur.
  function automatic logic [31:0] rand_coord(int max_shift);
    logic signed [31:0] x;
    x = $urandom;
    return x >>> $urandom_range(max_shift, 31);
  endfunction

  // Mostly aimed rays with random content; the rest is raw noise.
  function automatic ray_item_t rand_ray();
    ray_item_t it;
    wide_t cw, ow, dw;
    int sh;
    if ($urandom_range(99) < 20) begin
      for (int i = 0; i < 3; i++) begin
        it.o[i] = $urandom;
        it.d[i] = $urandom;
        it.c[i] = $urandom;
      end
      it.r = 31'($urandom);
      return it;
    end
    sh = $urandom_range(4, 14);
    for (int i = 0; i < 3; i++) begin
      it.c[i] = rand_coord(sh);
      cw = $signed(it.c[i]);
      ow = cw + $signed(rand_coord(sh));
      it.o[i] = 32'(ow);
      // aim back toward the center, with some noise and random scale
      dw = (cw - $signed(it.o[i])) >>> $urandom_range(0, 8);
      dw = dw + ($signed(rand_coord(20)) >>> $urandom_range(0, 10));
      if ($urandom_range(9) == 0) dw = -dw;
      it.d[i] = 32'(dw);
    end
    it.r = 31'(rand_coord(sh));
    if ($urandom_range(9) == 0) it.r = 31'($urandom);
    return it;
  endfunction

  task automatic add_ray(longint ox, oy, oz, dx, dy, dz, cx, cy, cz, r);
    ray_item_t it;
    it.o[0] = 32'(ox); it.o[1] = 32'(oy); it.o[2] = 32'(oz);
    it.d[0] = 32'(dx); it.d[1] = 32'(dy); it.d[2] = 32'(dz);
    it.c[0] = 32'(cx); it.c[1] = 32'(cy); it.c[2] = 32'(cz);
    it.r = 31'(r);
    ray_q.push_back(it);
  endtask

  task automatic wait_idle();
    while (ray_q.size() != 0 || in_valid || hit_exp_q.size() != 0) @(posedge clk);
  endtask

  // Driver: holds each item until accepted; predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) hit_exp_q.push_back(solve_hit(cur_ray));
      if (!in_valid || in_ready) begin
        if (ray_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_ray = ray_q.pop_front();
          ray_origin_x <= cur_ray.o[0];
          ray_origin_y <= cur_ray.o[1];
          ray_origin_z <= cur_ray.o[2];
          ray_dir_x    <= cur_ray.d[0];
          ray_dir_y    <= cur_ray.d[1];
          ray_dir_z    <= cur_ray.d[2];
          center_x     <= cur_ray.c[0];
          center_y     <= cur_ray.c[1];
          center_z     <= cur_ray.c[2];
          radius       <= cur_ray.r;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    hit_rec_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (hit_exp_q.size() == 0) begin
          $display("%0t: unexpected result hit=%0d dist=%0d", $time, hit, hit_distance);
          errors++;
        end else begin
          e = hit_exp_q.pop_front();
          if (hit !== e.hit) begin
            $display("%0t: hit exp %0d got %0d", $time, e.hit, hit);
            errors++;
          end
          if (hit_distance !== e.distance) begin
            $display("%0t: hit_distance exp %0d got %0d", $time, e.distance, hit_distance);
            errors++;
          end
          if (hit_point_x !== e.p[0] || hit_point_y !== e.p[1] || hit_point_z !== e.p[2]) begin
            $display("%0t: hit_point exp %0d %0d %0d got %0d %0d %0d", $time,
                     $signed(e.p[0]), $signed(e.p[1]), $signed(e.p[2]),
                     hit_point_x, hit_point_y, hit_point_z);
            errors++;
          end
          if (normal_x !== e.n[0] || normal_y !== e.n[1] || normal_z !== e.n[2]) begin
            $display("%0t: normal exp %0d %0d %0d got %0d %0d %0d", $time,
                     $signed(e.n[0]), $signed(e.n[1]), $signed(e.n[2]),
                     normal_x, normal_y, normal_z);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: cycles with no accept on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    longint u;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    {ray_origin_x, ray_origin_y, ray_origin_z} = '0;
    {ray_dir_x, ray_dir_y, ray_dir_z} = '0;
    {center_x, center_y, center_z} = '0;
    radius = '0;
    u = 65536;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: plain hit, zero direction, miss, behind, tangent, t = 0
    add_ray(0, 0, -10*u, 0, 0, u, 0, 0, 0, 2*u);
    add_ray(0, 0, -10*u, 0, 0, 0, 0, 0, 0, 2*u);
    add_ray(5*u, 0, -10*u, 0, 0, u, 0, 0, 0, 2*u);
    add_ray(0, 0, 10*u, 0, 0, u, 0, 0, 0, 2*u);
    add_ray(2*u, 0, -10*u, 0, 0, u, 0, 0, 0, 2*u);
    add_ray(0, 0, 2*u, 0, 0, u, 0, 0, 0, 2*u);
    add_ray(0, 0, 0, u, 0, 0, 0, 0, 0, 3*u);       // origin inside
    // hit point at center: zero-radius sphere on the ray
    add_ray(0, 0, -5*u, 0, 0, u, 0, 0, 0, 0);
    // saturated distance: tiny direction, distant sphere
    add_ray(0, 0, 0, 0, 0, 1, 0, 0, 30000*u, u);
    // saturated hit point: huge direction, far sphere
    add_ray(0, 0, 0, 32'h7fffffff, 0, 0, 32'h7fff0000, 0, 0, 32'h7fffffff);
    // field extremes
    add_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
    add_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
            -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
            -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 31'h7fffffff);
    add_ray(-64'sd2147483648, 0, 0, 32'h7fffffff, 0, 0, 32'h7fffffff, 0, 0, 31'h7fffffff);
    add_ray(32'h7fffffff, 0, 0, -64'sd2147483648, 0, 0, -64'sd2147483648, 0, 0, 0);
    add_ray(0, 0, 0, -u, -u, -u, -3*u, -3*u, -3*u, u);
    add_ray(1, -1, 1, -1, 1, -1, 0, 0, 0, 0);
    wait_idle();

    // random phases; the wait between them pauses the sender until drained
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      for (int k = 0; k < 100; k++) ray_q.push_back(rand_ray());
      wait_idle();
    end
    idle_pct = 0;
    stall_pct = 0;
    for (int k = 0; k < 10; k++) ray_q.push_back(rand_ray());
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && hit_exp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
